// ----- design/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the parity split sorter
// Cell contents, the command broadcast along the chain and the control states.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int DATA_W             = 16;
    localparam int MAX_ITEMS_DEFAULT  = 32;
    localparam int VALUE_BITS_DEFAULT = 16;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
    } cell_t;

    typedef struct packed {
        logic              insert;
        logic              shift;
        logic [DATA_W-1:0] key;
    } cmd_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage

// ----- design/psd_cell.sv -----
// ----------------------------------------------------------------------------
// psd_cell: one slot of the insertion chain
// Holds one value; takes the new key, its left neighbour's value or its right
// neighbour's value (during output) so the chain stays sorted.
// ----------------------------------------------------------------------------
module psd_cell
    import psd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cmd_t  cmd,
    input  cell_t left_in,
    input  logic  left_place,
    input  cell_t right_in,
    output cell_t state,
    output logic  place,
    output logic  eq
);

    cell_t                 cell_reg;
    cell_t                 cell_next;
    logic [DATA_W:0]       own_key;
    logic [DATA_W:0]       new_key;

    // Order key: even group before odd, ascending within a group
    assign own_key = {cell_reg.value[0], cell_reg.value};
    assign new_key = {cmd.key[0], cmd.key};

    assign place = !cell_reg.valid || (own_key > new_key);
    assign eq    = cell_reg.valid && (cell_reg.value == cmd.key);
    assign state = cell_reg;

    always_comb begin
        cell_next = cell_reg;
        priority if (cmd.shift) begin
            cell_next = right_in;
        end else if (cmd.insert && left_place) begin
            cell_next = left_in;
        end else if (cmd.insert && place) begin
            cell_next.valid = 1'b1;
            cell_next.value = cmd.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg.valid <= cell_next.valid;
        end
        cell_reg.value <= cell_next.value;
    end

endmodule

// ----- design/parity_split_sort_dedup.sv -----
// ----------------------------------------------------------------------------
// parity_split_sort_dedup: sort a set, drop duplicates, even values first
// Loads one value per request into a sorted chain of cells, then streams the
// distinct values out, the even group ascending followed by the odd group.
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | s_valid s_ready s_address s_last_item        | in
//  result  | m_valid m_ready m_value m_is_odd             | out
//          | m_last_result m_dropped                      |
//
// During loading every cell compares its value with the new key in parallel and
// the cells from the insertion point on shift right by one slot to take it.
// The request marked last ends loading; the chain then drains through cell 0,
// one result per cycle while m_ready is high, and s_ready stays low until the
// last result is taken.
// Reset (aresetn low, synchronous) empties the chain and clears the counters.
// A stalled result holds in cell 0 until it is taken.
// ----------------------------------------------------------------------------
module parity_split_sort_dedup
    import psd_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_address,
    input  logic              s_last_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_value,
    output logic              m_is_odd,
    output logic              m_last_result,
    output logic              m_dropped
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [DATA_W-1:0] KEEP_MASK = (VALUE_BITS >= DATA_W) ?
        {DATA_W{1'b1}} : DATA_W'((33'd1 << VALUE_BITS) - 33'd1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;

    cmd_t             cmd;
    cell_t            cells    [MAX_ITEMS];
    logic             places   [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] eq_vec;

    logic             s_accept;
    logic             m_accept;
    logic             full;
    logic             dup;
    logic             tail_empty;

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (state_reg == ST_DRAIN) && cells[0].valid;
    assign m_accept = m_valid && m_ready;

    assign full = (count_reg == CNT_FULL);
    assign dup  = |eq_vec;

    // Broadcast the masked key; skip insertion of a value already held or when full
    always_comb begin
        cmd        = '0;
        cmd.key    = s_address & KEEP_MASK;
        cmd.insert = s_accept && !full && !dup;
        cmd.shift  = m_accept;
    end

    generate
        if (MAX_ITEMS > 1) begin : g_tail
            assign tail_empty = !cells[1].valid;
        end else begin : g_single
            assign tail_empty = 1'b1;
        end
    endgenerate

    // Row of cells: left neighbour feeds insertion, right neighbour the drain.
    // A cell whose left neighbour is at or past the insertion point takes the
    // neighbour's contents, so only the first placing cell takes the new key.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            cell_t left_c;
            cell_t right_c;
            logic  left_p;

            if (gi == 0) begin : g_head
                assign left_c = '0;
                assign left_p = 1'b0;
            end else begin : g_body
                assign left_c = cells[gi-1];
                assign left_p = places[gi-1];
            end

            if (gi == MAX_ITEMS - 1) begin : g_end
                assign right_c = '0;
            end else begin : g_mid
                assign right_c = cells[gi+1];
            end

            psd_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .left_in    (left_c),
                .left_place (left_p),
                .right_in   (right_c),
                .state      (cells[gi]),
                .place      (places[gi]),
                .eq         (eq_vec[gi])
            );
        end
    endgenerate

    // Results come straight off the head cell
    assign m_value       = cells[0].value;
    assign m_is_odd      = cells[0].value[0];
    assign m_last_result = tail_empty;
    assign m_dropped     = overflow_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    // Count every accepted request, duplicates too; drop past capacity
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_last_item) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_accept && tail_empty) begin
                    state_next    = ST_LOAD;
                    count_next    = '0;
                    overflow_next = 1'b0;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

// ----- test/parity_split_sort_dedup_checker.sv -----
// ----------------------------------------------------------------------------
// parity_split_sort_dedup_checker: result predictor and scoreboard
// Watches both channels of the sorter, rebuilds each set from the accepted
// requests, works out the distinct values in output order and checks every
// accepted result against them.
// ----------------------------------------------------------------------------
module parity_split_sort_dedup_checker
    import psd_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEFAULT,
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [DATA_W-1:0] s_address,
    input  logic              s_last_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [DATA_W-1:0] m_value,
    input  logic              m_is_odd,
    input  logic              m_last_result,
    input  logic              m_dropped,
    output int                fail_count,
    output int                pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              is_odd;
        logic              last_result;
        logic              dropped;
    } sorted_result_t;

    localparam logic [DATA_W-1:0] KEEP_MASK =
        (VALUE_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << VALUE_BITS) - 1);

    logic [DATA_W-1:0] set_values[$];
    logic              set_overflow;
    sorted_result_t    expected_results[$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        set_overflow    = 1'b0;
    end

    // Sort the set, keep one copy of each value, even group then odd group.
    task automatic queue_sorted_run();
        logic [DATA_W-1:0] ordered[$];
        logic [DATA_W-1:0] distinct[$];
        sorted_result_t    res;
        int                emitted;
        ordered = set_values;
        ordered.sort();
        foreach (ordered[i]) begin
            if (distinct.size() == 0 || distinct[distinct.size()-1] != ordered[i]) begin
                distinct.push_back(ordered[i]);
            end
        end
        emitted = 0;
        for (int parity = 0; parity < 2; parity++) begin
            foreach (distinct[i]) begin
                if (distinct[i][0] == parity[0]) begin
                    res.value       = distinct[i];
                    res.is_odd      = parity[0];
                    res.last_result = (emitted == distinct.size() - 1);
                    res.dropped     = set_overflow;
                    expected_results.push_back(res);
                    emitted++;
                end
            end
        end
        set_values.delete();
        set_overflow = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        sorted_result_t want;
        if (!aresetn) begin
            set_values.delete();
            set_overflow = 1'b0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (set_values.size() < MAX_ITEMS) begin
                    set_values.push_back(s_address & KEEP_MASK);
                end else begin
                    set_overflow = 1'b1;
                end
                if (s_last_item) begin
                    queue_sorted_run();
                end
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display({"%0t: unexpected result, expected none, ",
                              "got value %h odd %b last %b dropped %b"},
                             $time, m_value, m_is_odd, m_last_result, m_dropped);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("value", want.value, m_value);
                    check_field("is_odd", DATA_W'(want.is_odd), DATA_W'(m_is_odd));
                    check_field("last_result", DATA_W'(want.last_result),
                                DATA_W'(m_last_result));
                    check_field("dropped", DATA_W'(want.dropped), DATA_W'(m_dropped));
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

// ----- test/parity_split_sort_dedup_tb.sv -----
// ----------------------------------------------------------------------------
// parity_split_sort_dedup_tb: stimulus and verdict for the parity split sorter
// Feeds directed and random sets of addresses with random gaps on both
// channels, holds the result channel off for a long stretch once so that the
// input backs up, and reports the outcome from the checker's failure count.
// ----------------------------------------------------------------------------
module parity_split_sort_dedup_tb
    import psd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TARGET = 165;  // requests before the random part winds down
    localparam int HOLD_AT       = 40;   // requests accepted before the long hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 20;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [DATA_W-1:0] s_address;
    logic              s_last_item;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_value;
    logic              m_is_odd;
    logic              m_last_result;
    logic              m_dropped;

    int fail_count;
    int pending_results;
    int requests_sent;
    bit eager_sender;  // set for whole sets that go in back to back

    parity_split_sort_dedup i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_address     (s_address),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_is_odd      (m_is_odd),
        .m_last_result (m_last_result),
        .m_dropped     (m_dropped)
    );

    parity_split_sort_dedup_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_address       (s_address),
        .s_last_item     (s_last_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_is_odd        (m_is_odd),
        .m_last_result   (m_last_result),
        .m_dropped       (m_dropped),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Mix full-range values with narrow bands so that duplicates are common.
    function automatic logic [DATA_W-1:0] pick_address();
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return DATA_W'($urandom_range(0, 65535));
            5, 6, 7:       return DATA_W'($urandom_range(0, 15));
            8:             return DATA_W'($urandom_range(0, 1)) |
                                  ($urandom_range(0, 1) ? 16'hFFFE : 16'h0000);
            default:       return 16'hFFF0 | DATA_W'($urandom_range(0, 15));
        endcase
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic load_value(input logic [DATA_W-1:0] addr, input logic last);
        int gap;
        gap = eager_sender ? 0 : pick_idle();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_address   <= addr;
        s_last_item <= last;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic load_random_set(input int set_size);
        eager_sender = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < set_size; k++) begin
            load_value(pick_address(), k == set_size - 1);
        end
        eager_sender = 1'b0;
    endtask

    // Stimulus: reset, directed sets, then random sets of mostly small size.
    initial begin
        int r;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_address     <= '0;
        s_last_item   <= 1'b0;
        requests_sent  = 0;
        eager_sender   = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // A set of one odd value, then one of one even value.
        load_value(16'hFFFF, 1'b1);
        load_value(16'h0000, 1'b1);
        // Mixed set with duplicates in both groups and both extremes.
        load_value(16'h0005, 1'b0);
        load_value(16'h0002, 1'b0);
        load_value(16'h0002, 1'b0);
        load_value(16'hFFFF, 1'b0);
        load_value(16'h0000, 1'b0);
        load_value(16'h0005, 1'b0);
        load_value(16'h0001, 1'b0);
        load_value(16'hFFFE, 1'b1);
        // Even only, all the same: collapse to a single result.
        load_value(16'h0008, 1'b0);
        load_value(16'h0008, 1'b0);
        load_value(16'h0008, 1'b1);
        // Odd only, out of order.
        load_value(16'h0003, 1'b0);
        load_value(16'h0001, 1'b0);
        load_value(16'h0007, 1'b0);
        load_value(16'h0003, 1'b1);
        // Alternating bit patterns.
        load_value(16'hAAAA, 1'b0);
        load_value(16'h5555, 1'b1);

        // Exactly full, then full with the closing request dropped.
        load_random_set(MAX_ITEMS_DEFAULT);
        load_random_set(MAX_ITEMS_DEFAULT + 1);
        while (requests_sent < RANDOM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 85) load_random_set($urandom_range(1, 12));
            else if (r < 95) load_random_set($urandom_range(13, MAX_ITEMS_DEFAULT));
            else load_random_set($urandom_range(MAX_ITEMS_DEFAULT + 1, MAX_ITEMS_DEFAULT + 8));
        end
        // Well past capacity, several requests dropped before the closing one.
        load_random_set(MAX_ITEMS_DEFAULT + 8);
        s_valid <= 1'b0;

        // Drain: wait for the last expected result, then let any stray ones show.
        @(negedge aclk);
        while (pending_results != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("parity_split_sort_dedup test passed");
        end else begin
            $display("parity_split_sort_dedup test failed");
        end
        $finish;
    end

    // Result side: random ready pattern, plus one long hold-off while the
    // sender keeps offering so that results back up and input stalls.
    initial begin
        int low_len;
        bit hold_done;
        hold_done = 1'b0;
        m_ready  <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!hold_done && requests_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(0, 9) == 0 ? 50 : $urandom_range(1, 12)) @(posedge aclk);
                low_len = pick_idle();
                if (low_len > 0) begin
                    m_ready <= 1'b0;
                    repeat (low_len) @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("parity_split_sort_dedup test failed");
        $finish;
    end

endmodule
